### sv/fircirc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fircirc_pkg
// Shared sizes, codes and control bundles of the circular-buffer FIR filter.
// ----------------------------------------------------------------------------
package fircirc_pkg;

  localparam int MAX_TAPS     = 16;
  localparam int SAMPLE_BITS  = 16;
  localparam int ACC_BITS     = 40;
  localparam int FRAC_BITS    = SAMPLE_BITS - 1;
  localparam int PROD_BITS    = 2 * SAMPLE_BITS;
  localparam int DIGIT_BITS   = 4;
  localparam int DIGITS       = SAMPLE_BITS / DIGIT_BITS;
  localparam int DIG_CNT_BITS = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int TAP_IDX_BITS = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TAP_CNT_BITS = 5;
  localparam int COEF_IDX_BITS = 4;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [TAP_CNT_BITS-1:0] TAP_COUNT_RESET = TAP_CNT_BITS'(16);

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_SAMPLE  = 2'd1,
    OP_RESTART = 2'd2
  } opcode_t;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_TAP_COUNT  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INIT_VALUE = CFG_INDEX_BITS'(1);

  // Writes into the coefficient table and the delay line
  typedef struct packed {
    logic                          coef_we;
    logic [TAP_IDX_BITS-1:0]       coef_addr;
    logic                          delay_we;
    logic [TAP_IDX_BITS-1:0]       delay_addr;
    logic                          fill;
    logic signed [SAMPLE_BITS-1:0] wdata;
  } store_ctrl_t;

  // Steps of the digit-serial multiply-accumulate
  typedef struct packed {
    logic clear;   // start of a sample: zero product and accumulator
    logic load;    // take next tap operands, fold previous product in
    logic step;    // one digit of the multiply
    logic first;   // this step handles the most significant digit
    logic accum;   // fold the last product in
  } mac_ctrl_t;

endpackage
`default_nettype wire

### sv/fircirc_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fircirc_store
// Coefficient table and circular delay line, flop based, one read each.
// ----------------------------------------------------------------------------
module fircirc_store (
  input  wire                                          clk,
  input  wire                                          rst,
  input  wire  fircirc_pkg::store_ctrl_t               ctrl,
  input  wire  [fircirc_pkg::TAP_IDX_BITS-1:0]         coef_raddr,
  input  wire  [fircirc_pkg::TAP_IDX_BITS-1:0]         delay_raddr,
  output logic signed [fircirc_pkg::SAMPLE_BITS-1:0]   coef_rdata,
  output logic signed [fircirc_pkg::SAMPLE_BITS-1:0]   delay_rdata
);

  logic signed [fircirc_pkg::SAMPLE_BITS-1:0] coef  [fircirc_pkg::MAX_TAPS];
  logic signed [fircirc_pkg::SAMPLE_BITS-1:0] delay [fircirc_pkg::MAX_TAPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < fircirc_pkg::MAX_TAPS; k++) begin
        coef[k]  <= '0;
        delay[k] <= '0;
      end
    end else begin
      if (ctrl.coef_we) begin
        coef[ctrl.coef_addr] <= ctrl.wdata;
      end
      if (ctrl.fill) begin
        for (int k = 0; k < fircirc_pkg::MAX_TAPS; k++) begin
          delay[k] <= ctrl.wdata;
        end
      end else if (ctrl.delay_we) begin
        delay[ctrl.delay_addr] <= ctrl.wdata;
      end
    end
  end

  assign coef_rdata  = coef[coef_raddr];
  assign delay_rdata = delay[delay_raddr];

endmodule
`default_nettype wire

### sv/fircirc_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fircirc_mac
// Digit-serial multiply-accumulate with Q1.15 rounding and saturation.
// ----------------------------------------------------------------------------
module fircirc_mac (
  input  wire                                          clk,
  input  wire  fircirc_pkg::mac_ctrl_t                 ctrl,
  input  wire  signed [fircirc_pkg::SAMPLE_BITS-1:0]   coef_in,
  input  wire  signed [fircirc_pkg::SAMPLE_BITS-1:0]   sample_in,
  output logic signed [fircirc_pkg::SAMPLE_BITS-1:0]   filtered,
  output logic                                         saturated
);

  localparam int SB     = fircirc_pkg::SAMPLE_BITS;
  localparam int DB     = fircirc_pkg::DIGIT_BITS;
  localparam int AB     = fircirc_pkg::ACC_BITS;
  localparam int PB     = fircirc_pkg::PROD_BITS;
  localparam int Q_BITS = AB + 1 - fircirc_pkg::FRAC_BITS;
  localparam logic signed [AB:0]       ROUND_HALF = (AB + 1)'(1) <<< (fircirc_pkg::FRAC_BITS - 1);
  localparam logic signed [Q_BITS-1:0] QMAX = Q_BITS'((1 <<< (SB - 1)) - 1);
  localparam logic signed [Q_BITS-1:0] QMIN = -QMAX - Q_BITS'(1);

  logic signed [SB-1:0]    coef;
  logic        [SB-1:0]    xs;     // sample, shifted out MSB digit first
  logic signed [PB-1:0]    prod;
  logic signed [AB-1:0]    acc;
  logic signed [DB:0]      digit;
  logic signed [SB+DB:0]   partial;
  logic signed [AB:0]      rounded;
  logic signed [Q_BITS-1:0] q;
  logic                    sat_hi;
  logic                    sat_lo;

  // top digit carries the sign of the sample, the rest are unsigned
  assign digit   = ctrl.first ? {xs[SB-1], xs[SB-1 -: DB]} : {1'b0, xs[SB-1 -: DB]};
  assign partial = coef * digit;

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      prod <= '0;
      acc  <= '0;
    end else begin
      if (ctrl.load) begin
        coef <= coef_in;
        xs   <= sample_in;
      end
      if (ctrl.load || ctrl.accum) begin
        acc <= acc + AB'(prod);
      end
      if (ctrl.step) begin
        prod <= (ctrl.first ? PB'(0) : (prod <<< DB)) + PB'(partial);
        xs   <= xs << DB;
      end
    end
  end

  // round half up, then floor to Q1.15
  assign rounded   = (AB + 1)'(acc) + ROUND_HALF;
  assign q         = Q_BITS'(rounded >>> fircirc_pkg::FRAC_BITS);
  assign sat_hi    = q > QMAX;
  assign sat_lo    = q < QMIN;
  assign saturated = sat_hi || sat_lo;
  assign filtered  = sat_hi ? {1'b0, {(SB - 1){1'b1}}} :
                     sat_lo ? {1'b1, {(SB - 1){1'b0}}} : q[SB-1:0];

endmodule
`default_nettype wire

### sv/fir_filter_circular_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fir_filter_circular_unit
// Direct-form FIR filter over a circular delay line, digit-serial MAC.
// ----------------------------------------------------------------------------
// Coefficient loads and restarts are taken in the idle state and may go on
// while a result waits on the output. A sample item walks the active taps
// with one shared multiplier that consumes the sample four bits per cycle:
// each tap takes an operand fetch followed by the multiply of its four
// digits. No new item is taken after a sample until its result is handed
// over; the walk is lengthened when a stored write position beyond a
// shortened tap count must first be reduced, and by any output stall.
module fir_filter_circular_unit (
  input  wire                                       clk,
  input  wire                                       rst,
  // configuration writes
  input  wire                                       cfg_valid,
  output logic                                      cfg_ready,
  input  wire  [fircirc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire  [fircirc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  // input items
  input  wire                                       s_tvalid,
  output logic                                      s_tready,
  input  wire  [23:0]                               s_tdata,  // coef_index[3:0], value[19:4]
  input  wire  [1:0]                                s_tuser,  // opcode[1:0]
  // result items
  output logic                                      m_tvalid,
  input  wire                                       m_tready,
  output logic [15:0]                               m_tdata,  // filtered[15:0]
  output logic                                      m_tuser   // saturated
);

  localparam int TIB = fircirc_pkg::TAP_IDX_BITS;
  localparam int TCB = fircirc_pkg::TAP_CNT_BITS;
  localparam int SB  = fircirc_pkg::SAMPLE_BITS;
  localparam int DCB = fircirc_pkg::DIG_CNT_BITS;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_NORM  = 6'b000010,
    ST_LOAD  = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_FLUSH = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t                    state, state_next;
  logic [TCB-1:0]            tap_count;
  logic signed [SB-1:0]      init_value;
  logic [TIB-1:0]            wp;
  logic [TIB-1:0]            tap_i;
  logic [TIB-1:0]            tap_j;
  logic [DCB-1:0]            dig;
  logic signed [SB-1:0]      x_in;
  logic [TCB-1:0]            n_taps;
  logic [TCB-1:0]            wp_inc;
  logic                      in_fire;
  logic                      out_free;
  logic                      last_tap;
  logic                      last_dig;

  fircirc_pkg::opcode_t      opcode;
  logic [fircirc_pkg::COEF_IDX_BITS-1:0] coef_index;
  logic signed [SB-1:0]      value;

  fircirc_pkg::store_ctrl_t  st_ctrl;
  fircirc_pkg::mac_ctrl_t    mac_ctrl;
  logic signed [SB-1:0]      coef_rdata;
  logic signed [SB-1:0]      delay_rdata;
  logic signed [SB-1:0]      mac_filtered;
  logic                      mac_saturated;

  assign opcode     = fircirc_pkg::opcode_t'(s_tuser);
  assign coef_index = s_tdata[3:0];
  assign value      = s_tdata[19:4];

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // active taps: tap_count clamped into 1..MAX_TAPS
  always_comb begin
    if (tap_count == '0) begin
      n_taps = TCB'(1);
    end else if (tap_count > TCB'(fircirc_pkg::MAX_TAPS)) begin
      n_taps = TCB'(fircirc_pkg::MAX_TAPS);
    end else begin
      n_taps = tap_count;
    end
  end

  assign last_tap = ({1'b0, tap_i} == n_taps - TCB'(1));
  assign last_dig = (dig == DCB'(fircirc_pkg::DIGITS - 1));
  assign wp_inc   = {1'b0, wp} + TCB'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count  <= fircirc_pkg::TAP_COUNT_RESET;
      init_value <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fircirc_pkg::CFG_TAP_COUNT:  tap_count  <= cfg_data[TCB-1:0];
        fircirc_pkg::CFG_INIT_VALUE: init_value <= cfg_data[SB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && opcode == fircirc_pkg::OP_SAMPLE) begin
          state_next = ST_NORM;
        end
      end
      ST_NORM: begin
        if ({1'b0, wp} < n_taps) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: state_next = ST_MUL;
      ST_MUL: begin
        if (last_dig) begin
          state_next = last_tap ? ST_FLUSH : ST_LOAD;
        end
      end
      ST_FLUSH: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      wp    <= '0;
      tap_i <= '0;
      tap_j <= '0;
      dig   <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (in_fire && opcode == fircirc_pkg::OP_RESTART) begin
            wp <= '0;
          end
        end
        ST_NORM: begin
          // stale position after a shorter tap count: reduce modulo taps
          if ({1'b0, wp} >= n_taps) begin
            wp <= TIB'({1'b0, wp} - n_taps);
          end else begin
            tap_i <= '0;
            tap_j <= wp;
          end
        end
        ST_LOAD: dig <= '0;
        ST_MUL: begin
          dig <= dig + DCB'(1);
          if (last_dig) begin
            tap_i <= tap_i + TIB'(1);
            tap_j <= (tap_j == '0) ? TIB'(n_taps - TCB'(1)) : tap_j - TIB'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            wp <= (wp_inc == n_taps) ? '0 : TIB'(wp_inc);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_in <= value;
    end
  end

  always_comb begin
    st_ctrl            = '0;
    st_ctrl.coef_addr  = TIB'(coef_index);
    st_ctrl.delay_addr = wp;
    st_ctrl.wdata      = value;
    if (state == ST_IDLE && in_fire) begin
      if (opcode == fircirc_pkg::OP_LOAD) begin
        st_ctrl.coef_we = (int'(coef_index) < fircirc_pkg::MAX_TAPS);
      end else if (opcode == fircirc_pkg::OP_RESTART) begin
        st_ctrl.fill  = 1'b1;
        st_ctrl.wdata = init_value;
      end
    end else if (state == ST_NORM && {1'b0, wp} < n_taps) begin
      st_ctrl.delay_we = 1'b1;
      st_ctrl.wdata    = x_in;
    end
  end

  always_comb begin
    mac_ctrl       = '0;
    mac_ctrl.clear = (state == ST_NORM);
    mac_ctrl.load  = (state == ST_LOAD);
    mac_ctrl.step  = (state == ST_MUL);
    mac_ctrl.first = (dig == '0);
    mac_ctrl.accum = (state == ST_FLUSH);
  end

  fircirc_store u_store (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (st_ctrl),
    .coef_raddr  (tap_i),
    .delay_raddr (tap_j),
    .coef_rdata  (coef_rdata),
    .delay_rdata (delay_rdata)
  );

  fircirc_mac u_mac (
    .clk       (clk),
    .ctrl      (mac_ctrl),
    .coef_in   (coef_rdata),
    .sample_in (delay_rdata),
    .filtered  (mac_filtered),
    .saturated (mac_saturated)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= mac_filtered;
      m_tuser <= mac_saturated;
    end
  end

  // operand fetch stays inside the active taps
  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |-> ({1'b0, tap_i} < n_taps && {1'b0, tap_j} < n_taps))
    else $error("tap index outside active taps");

  // the result stage is reached only through the final accumulate
  a_done_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && $past(state) != ST_DONE) |-> $past(state) == ST_FLUSH)
    else $error("result stage entered without final accumulate");

  // a new result appears only when the result stage hands it over
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_DONE)
    else $error("result item without a finished sample");

  // the write position stays normalized once the walk has started
  a_wp_norm: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |-> {1'b0, wp} < n_taps)
    else $error("write position beyond active taps");

endmodule
`default_nettype wire

### sim/tb_fir_filter_circular_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fir_filter_circular_unit
// Self-checking bench for the circular-buffer FIR filter. A bit-exact model
// of taps, delay line and rounding predicts every filtered item. Directed
// corner items come first, then random phases over many tap counts and fill
// values, with source gaps, sink stalls and two long output hold-offs.
// ----------------------------------------------------------------------------
module tb_fir_filter_circular_unit;
  import fircirc_pkg::*;

  localparam logic [1:0] OP_UNDEFINED = 2'd3;
  localparam int STUCK_LIMIT  = 4000;  // cycles with no handshake on any channel
  localparam int DRAIN_CYCLES = 200;
  localparam int LONG_HOLD    = 600;
  localparam int PHASES       = 8;

  typedef struct packed {
    logic [15:0] filtered;
    logic        saturated;
  } fir_out_t;

  // Bit-exact filter model plus the queue of outputs it still owes
  class fir_output_model;
    logic signed [15:0] coef_mem [MAX_TAPS];
    logic signed [15:0] hist_mem [MAX_TAPS];
    int unsigned        wr_pos;
    logic [4:0]         tap_count;
    logic signed [15:0] fill_value;
    fir_out_t           owed_outputs [$];
    int unsigned        errors;

    function new();
      for (int i = 0; i < MAX_TAPS; i++) begin
        coef_mem[i] = '0;
        hist_mem[i] = '0;
      end
      wr_pos     = 0;
      tap_count  = TAP_COUNT_RESET;
      fill_value = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [15:0] data);
      if (idx == CFG_TAP_COUNT) begin
        tap_count = data[4:0];
      end else begin
        fill_value = data;
      end
    endfunction

    function void take_item(logic [1:0] op, logic [3:0] idx, logic signed [15:0] v);
      int unsigned        n;
      int unsigned        p;
      int unsigned        j;
      longint             prod;
      logic signed [39:0] acc;
      longint             rounded;
      fir_out_t           res;
      case (op)
        OP_LOAD: begin
          coef_mem[idx] = v;
        end
        OP_RESTART: begin
          for (int i = 0; i < MAX_TAPS; i++) hist_mem[i] = fill_value;
          wr_pos = 0;
        end
        OP_SAMPLE: begin
          n = (tap_count == 0) ? 1 : (tap_count > MAX_TAPS) ? MAX_TAPS : tap_count;
          p = wr_pos % n;  // position may be stale after a shorter tap count
          hist_mem[p] = v;
          acc = '0;
          for (int i = 0; i < n; i++) begin
            j = (p + n - i) % n;
            prod = longint'(coef_mem[i]) * longint'(hist_mem[j]);
            acc = acc + 40'(prod);
          end
          // round half up from Q2.30, floor via arithmetic shift
          rounded = (longint'(acc) + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
          res.saturated = 1'b0;
          if (rounded > 32767) begin
            rounded = 32767;
            res.saturated = 1'b1;
          end else if (rounded < -32768) begin
            rounded = -32768;
            res.saturated = 1'b1;
          end
          res.filtered = 16'(rounded);
          owed_outputs.push_back(res);
          wr_pos = (p + 1) % n;
        end
        default: ;
      endcase
    endfunction

    function void check_output(logic [15:0] filtered, logic saturated);
      fir_out_t exp_out;
      if (owed_outputs.size() == 0) begin
        $display("%0t: unexpected output item, got filtered %h saturated %b",
                 $time, filtered, saturated);
        errors++;
        return;
      end
      exp_out = owed_outputs.pop_front();
      if (filtered !== exp_out.filtered) begin
        $display("%0t: filtered mismatch, expected %h, got %h",
                 $time, exp_out.filtered, filtered);
        errors++;
      end
      if (saturated !== exp_out.saturated) begin
        $display("%0t: saturated mismatch, expected %b, got %b",
                 $time, exp_out.saturated, saturated);
        errors++;
      end
    endfunction

    function int unsigned owed();
      return owed_outputs.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [23:0]               s_tdata = '0;  // coef_index[3:0], value[19:4]
  logic [1:0]                s_tuser = '0;  // opcode[1:0]
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [15:0]               m_tdata;       // filtered[15:0]
  logic                      m_tuser;       // saturated

  int unsigned     src_idle_pct = 0;
  int unsigned     snk_stall_pct = 0;
  logic            hold_req = 1'b0;
  logic            hold_ack = 1'b0;
  int unsigned     hold_left = 0;
  int unsigned     stuck_cycles = 0;
  fir_output_model fir_model;

  fir_filter_circular_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Sink: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= LONG_HOLD;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Outputs are checked before the same edge's input is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) fir_model.check_output(m_tdata, m_tuser);
      if (s_tvalid && s_tready) fir_model.take_item(s_tuser, s_tdata[3:0], s_tdata[19:4]);
      if (cfg_valid && cfg_ready) fir_model.write_reg(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STUCK_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Valid stays high across back-to-back items; it drops only for a gap
  task automatic send_item(logic [1:0] op, logic [3:0] idx, logic [15:0] v);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 24'($urandom);
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0, v, idx};
    do @(posedge clk); while (!(s_tvalid && s_tready));
  endtask

  // Both registers in one burst; upper tap_count bits are don't-care
  task automatic write_regs(logic [4:0] taps, logic [15:0] fill);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TAP_COUNT;
    cfg_data  <= {11'($urandom), taps};
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_index <= CFG_INIT_VALUE;
    cfg_data  <= fill;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (fir_model.owed() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_value(int unsigned shift_max);
    logic [15:0] v;
    case ($urandom_range(7))
      0:       v = 16'h7FFF;
      1:       v = 16'h8000;
      2:       v = 16'h0000;
      default: v = 16'($signed(16'($urandom)) >>> $urandom_range(shift_max));
    endcase
    return v;
  endfunction

  // Mostly restart/load-all/sample sequences, with some stray opcodes mixed in
  task automatic run_random(int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    if ($urandom_range(1) == 1) begin
      send_item(OP_RESTART, 4'($urandom), 16'($urandom));
      sent++;
    end
    for (int k = 0; k < MAX_TAPS; k++) begin
      send_item(OP_LOAD, 4'(k), rand_value(5));
      sent++;
    end
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_item(OP_SAMPLE, 4'($urandom), rand_value(2));
        sent++;
      end else if (pick < 88) begin
        send_item(OP_LOAD, 4'($urandom), rand_value(5));
        sent++;
      end else if (pick < 94) begin
        send_item(OP_RESTART, 4'($urandom), 16'($urandom));
        sent++;
      end else begin
        send_item(OP_UNDEFINED, 4'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    logic [4:0]  tap_plan  [PHASES];
    logic [15:0] fill_plan [PHASES];
    fir_model = new();
    tap_plan  = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd17, 5'd7, 5'd16};
    fill_plan = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                  16'($urandom), 16'($urandom), 16'h8000, 16'h7FFF};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed corners at full length
    write_regs(5'd16, 16'h8000);
    send_item(OP_SAMPLE, 4'd0, 16'h7FFF);    // all coefficients still zero
    send_item(OP_LOAD, 4'd0, 16'h7FFF);
    send_item(OP_LOAD, 4'd15, 16'h8000);
    send_item(OP_SAMPLE, 4'd9, 16'h7FFF);
    send_item(OP_SAMPLE, 4'd0, 16'h8000);
    send_item(OP_UNDEFINED, 4'hF, 16'hFFFF); // ignored
    send_item(OP_RESTART, 4'd0, 16'h0000);   // fill with most negative value
    send_item(OP_LOAD, 4'd0, 16'h8000);
    send_item(OP_SAMPLE, 4'd0, 16'h8000);    // positive clip
    send_item(OP_LOAD, 4'd0, 16'h7FFF);
    send_item(OP_LOAD, 4'd15, 16'h7FFF);
    send_item(OP_SAMPLE, 4'd0, 16'h8000);    // negative clip
    send_item(OP_LOAD, 4'd15, 16'h0000);
    send_item(OP_LOAD, 4'd0, 16'h0080);
    send_item(OP_SAMPLE, 4'd0, 16'h0080);    // exact half rounds up to one
    send_item(OP_SAMPLE, 4'd0, 16'hFF80);    // exact minus half rounds up to zero
    send_item(OP_LOAD, 4'd1, 16'hFFFF);
    send_item(OP_SAMPLE, 4'd0, 16'h0001);
    send_item(OP_SAMPLE, 4'd0, 16'hFFFF);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin
          src_idle_pct  <= 0;
          snk_stall_pct <= 0;
        end
        1: begin
          src_idle_pct  <= 66;
          snk_stall_pct <= 0;
        end
        2: begin
          src_idle_pct  <= 0;
          snk_stall_pct <= 66;
        end
        default: begin
          src_idle_pct  <= 35;
          snk_stall_pct <= 35;
        end
      endcase
      write_regs(tap_plan[ph], fill_plan[ph]);
      // long output hold-off while the source keeps pushing
      if (ph % 4 == 0) hold_req <= ~hold_req;
      run_random(190);
      settle();
    end

    if (fir_model.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
